/* hw/rtl/ugil_pkg.sv */
package ugil_pkg;

  localparam int unsigned LEAD2_DEPTH_DEF   = 16;
  localparam int unsigned LEAD3_DEPTH_DEF   = 16;
  localparam int unsigned SECOND3_DEPTH_DEF = 256;
  localparam int unsigned CODES2_DEPTH_DEF  = 1024;
  localparam int unsigned CODES3_DEPTH_DEF  = 8192;

  localparam logic [2:0] FUNC_LOOKUP  = 3'd0;
  localparam logic [2:0] FUNC_LEAD2   = 3'd1;
  localparam logic [2:0] FUNC_LEAD3   = 3'd2;
  localparam logic [2:0] FUNC_SECOND3 = 3'd3;
  localparam logic [2:0] FUNC_CODES2  = 3'd4;
  localparam logic [2:0] FUNC_CODES3  = 3'd5;

  localparam logic REG_LEADS2 = 1'b0;
  localparam logic REG_LEADS3 = 1'b1;

  localparam logic [1:0] SET_ONE   = 2'd1;
  localparam logic [1:0] SET_TWO   = 2'd2;
  localparam logic [1:0] SET_THREE = 2'd3;

  localparam logic [7:0] MASK_B7  = 8'h80;
  localparam logic [7:0] MASK_2B  = 8'hE0;
  localparam logic [7:0] LEAD_2B  = 8'hC0;
  localparam logic [7:0] MASK_3B  = 8'hF0;
  localparam logic [7:0] LEAD_3B  = 8'hE0;
  localparam logic [7:0] MASK_4B  = 8'hF8;

  typedef enum logic [1:0] {
    KIND_ONE   = 2'd0,
    KIND_TWO   = 2'd1,
    KIND_THREE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [12:0] entry_index;
    logic [7:0]  entry_byte;
    logic [6:0]  entry_count;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [7:0]  third_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  bytes_used;
    logic [1:0]  glyph_set;
    logic [12:0] glyph_index;
  } out_word_t;

  typedef struct packed {
    in_word_t word;
    kind_e    kind;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_L2_RD,
    ST_L2_EV,
    ST_C2_RD,
    ST_C2_EV,
    ST_L3_RD,
    ST_L3_EV,
    ST_S3_RD,
    ST_S3_EV,
    ST_C3_RD,
    ST_C3_EV,
    ST_OUT
  } state_e;

endpackage

/* hw/rtl/ugil_front.sv */
module ugil_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ugil_pkg::in_word_t in_data_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output ugil_pkg::cmd_t    q_cmd_o
);

  ugil_pkg::cmd_t buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  ugil_pkg::kind_e kind;
  logic push;

  always_comb begin
    if ((in_data_i.first_byte & ugil_pkg::MASK_B7) == 8'h00) begin
      kind = ugil_pkg::KIND_ONE;
    end else if ((in_data_i.first_byte & ugil_pkg::MASK_2B) == ugil_pkg::LEAD_2B) begin
      kind = ugil_pkg::KIND_TWO;
    end else if ((in_data_i.first_byte & ugil_pkg::MASK_3B) == ugil_pkg::LEAD_3B) begin
      kind = ugil_pkg::KIND_THREE;
    end else begin
      kind = ugil_pkg::KIND_NONE;
    end
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= '{word: in_data_i, kind: kind};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= !wp_q;
      end
      if (q_pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count out of range");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> cnt_q != 2'd0) else $error("pop from empty queue");
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> in_stall_o) else $error("full queue not stalling");

endmodule

/* hw/rtl/ugil_back.sv */
module ugil_back #(
  parameter int unsigned LEAD2_DEPTH   = ugil_pkg::LEAD2_DEPTH_DEF,
  parameter int unsigned LEAD3_DEPTH   = ugil_pkg::LEAD3_DEPTH_DEF,
  parameter int unsigned SECOND3_DEPTH = ugil_pkg::SECOND3_DEPTH_DEF,
  parameter int unsigned CODES2_DEPTH  = ugil_pkg::CODES2_DEPTH_DEF,
  parameter int unsigned CODES3_DEPTH  = ugil_pkg::CODES3_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  ugil_pkg::cmd_t     q_cmd_i,
  input  logic [4:0]         leads2_i,
  input  logic [4:0]         leads3_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ugil_pkg::out_word_t out_data_o
);

  localparam int unsigned L2W = (LEAD2_DEPTH > 1) ? $clog2(LEAD2_DEPTH) : 1;
  localparam int unsigned L3W = (LEAD3_DEPTH > 1) ? $clog2(LEAD3_DEPTH) : 1;
  localparam int unsigned S3W = (SECOND3_DEPTH > 1) ? $clog2(SECOND3_DEPTH) : 1;
  localparam int unsigned C2W = (CODES2_DEPTH > 1) ? $clog2(CODES2_DEPTH) : 1;
  localparam int unsigned C3W = (CODES3_DEPTH > 1) ? $clog2(CODES3_DEPTH) : 1;

  logic [14:0] lead2_mem [LEAD2_DEPTH];
  logic [14:0] lead3_mem [LEAD3_DEPTH];
  logic [14:0] sec3_mem  [SECOND3_DEPTH];
  logic [7:0]  code2_mem [CODES2_DEPTH];
  logic [7:0]  code3_mem [CODES3_DEPTH];

  ugil_pkg::state_e state_q, state_d;
  logic [5:0]  i_q, i_d;
  logic [6:0]  j_q, j_d;
  logic [10:0] mid_q, mid_d;
  logic [17:0] pos_q, pos_d;
  logic [14:0] ent_q, rd_ent;
  logic [7:0]  code_q;
  logic        inner_q, inner_d;
  ugil_pkg::out_word_t res_q, res_d;
  ugil_pkg::out_word_t oword_q;
  logic        ovalid_q, ovalid_d;
  logic        pop;
  ugil_pkg::in_word_t w;
  logic [12:0] idx;

  assign w           = q_cmd_i.word;
  assign idx         = w.entry_index;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = oword_q;
  assign q_pop_o     = pop;

  always_ff @(posedge clk_i) begin
    if (q_valid_i && state_q == ugil_pkg::ST_IDLE) begin
      if (w.func == ugil_pkg::FUNC_LEAD2 && 32'(idx) < LEAD2_DEPTH) begin
        lead2_mem[idx[L2W-1:0]] <= {w.entry_count, w.entry_byte};
      end
      if (w.func == ugil_pkg::FUNC_LEAD3 && 32'(idx) < LEAD3_DEPTH) begin
        lead3_mem[idx[L3W-1:0]] <= {w.entry_count, w.entry_byte};
      end
      if (w.func == ugil_pkg::FUNC_SECOND3 && 32'(idx) < SECOND3_DEPTH) begin
        sec3_mem[idx[S3W-1:0]] <= {w.entry_count, w.entry_byte};
      end
      if (w.func == ugil_pkg::FUNC_CODES2 && 32'(idx) < CODES2_DEPTH) begin
        code2_mem[idx[C2W-1:0]] <= w.entry_byte;
      end
      if (w.func == ugil_pkg::FUNC_CODES3 && 32'(idx) < CODES3_DEPTH) begin
        code3_mem[idx[C3W-1:0]] <= w.entry_byte;
      end
    end
    case (state_q)
      ugil_pkg::ST_L2_RD: ent_q  <= lead2_mem[i_q[L2W-1:0]];
      ugil_pkg::ST_L3_RD: ent_q  <= lead3_mem[i_q[L3W-1:0]];
      ugil_pkg::ST_S3_RD: ent_q  <= sec3_mem[mid_q[S3W-1:0]];
      ugil_pkg::ST_C2_RD: code_q <= code2_mem[pos_q[C2W-1:0]];
      ugil_pkg::ST_C3_RD: code_q <= code3_mem[pos_q[C3W-1:0]];
      default: ;
    endcase
  end

  assign rd_ent = ent_q;

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    mid_d    = mid_q;
    pos_d    = pos_q;
    inner_d  = inner_q;
    res_d    = res_q;
    ovalid_d = ovalid_q && out_stall_i;
    pop      = 1'b0;
    case (state_q)
      ugil_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          i_d = '0; j_d = '0; mid_d = '0; pos_d = '0; inner_d = 1'b0;
          res_d = '0;
          if (w.func != ugil_pkg::FUNC_LOOKUP) begin
            pop = 1'b1;
          end else begin
            case (q_cmd_i.kind)
              ugil_pkg::KIND_ONE: begin
                res_d = '{bytes_used: 2'd1, glyph_set: ugil_pkg::SET_ONE,
                          glyph_index: {5'd0, w.first_byte}};
                state_d = ugil_pkg::ST_OUT;
              end
              ugil_pkg::KIND_TWO: state_d = ugil_pkg::ST_L2_RD;
              ugil_pkg::KIND_THREE: state_d = ugil_pkg::ST_L3_RD;
              default: state_d = ugil_pkg::ST_OUT;
            endcase
          end
        end
      end
      ugil_pkg::ST_L2_RD: begin
        if (i_q >= 6'(leads2_i)) begin
          state_d = ugil_pkg::ST_OUT;
        end else if (32'(i_q) >= LEAD2_DEPTH) begin
          state_d = ugil_pkg::ST_OUT;
        end else begin
          state_d = ugil_pkg::ST_L2_EV;
        end
      end
      ugil_pkg::ST_L2_EV: begin
        if (rd_ent[7:0] == w.first_byte) begin
          j_d = '0;
          state_d = ugil_pkg::ST_C2_RD;
        end else begin
          pos_d = pos_q + 18'(rd_ent[14:8]);
          i_d = i_q + 6'd1;
          state_d = ugil_pkg::ST_L2_RD;
        end
      end
      ugil_pkg::ST_C2_RD: begin
        if (j_q >= rd_ent[14:8]) begin
          i_d = i_q + 6'd1;
          state_d = ugil_pkg::ST_L2_RD;
        end else if (32'(pos_q) >= CODES2_DEPTH) begin
          state_d = ugil_pkg::ST_OUT;
        end else begin
          state_d = ugil_pkg::ST_C2_EV;
        end
      end
      ugil_pkg::ST_C2_EV: begin
        if (code_q == w.second_byte) begin
          res_d = '{bytes_used: 2'd2, glyph_set: ugil_pkg::SET_TWO,
                    glyph_index: pos_q[12:0]};
          state_d = ugil_pkg::ST_OUT;
        end else begin
          pos_d = pos_q + 18'd1;
          j_d = j_q + 7'd1;
          state_d = ugil_pkg::ST_C2_RD;
        end
      end
      ugil_pkg::ST_L3_RD: begin
        if (i_q >= 6'(leads3_i) || 32'(i_q) >= LEAD3_DEPTH) begin
          state_d = ugil_pkg::ST_OUT;
        end else begin
          state_d = ugil_pkg::ST_L3_EV;
        end
      end
      ugil_pkg::ST_L3_EV: begin
        inner_d = (rd_ent[7:0] == w.first_byte);
        j_d = rd_ent[14:8];
        state_d = ugil_pkg::ST_S3_RD;
        if (rd_ent[14:8] == 7'd0) begin
          i_d = i_q + 6'd1;
          state_d = ugil_pkg::ST_L3_RD;
        end else if (32'(mid_q) >= SECOND3_DEPTH) begin
          state_d = ugil_pkg::ST_OUT;
        end
      end
      ugil_pkg::ST_S3_RD: begin
        state_d = ugil_pkg::ST_S3_EV;
      end
      ugil_pkg::ST_S3_EV: begin
        if (inner_q && rd_ent[7:0] == w.second_byte) begin
          j_d = '0;
          state_d = ugil_pkg::ST_C3_RD;
        end else begin
          pos_d = pos_q + 18'(rd_ent[14:8]);
          mid_d = mid_q + 11'd1;
          j_d = j_q - 7'd1;
          if (j_q == 7'd1) begin
            i_d = i_q + 6'd1;
            state_d = ugil_pkg::ST_L3_RD;
          end else if (32'(mid_q) + 1 >= SECOND3_DEPTH) begin
            state_d = ugil_pkg::ST_OUT;
          end else begin
            state_d = ugil_pkg::ST_S3_RD;
          end
        end
      end
      ugil_pkg::ST_C3_RD: begin
        if (j_q >= rd_ent[14:8] || 32'(pos_q) >= CODES3_DEPTH) begin
          state_d = ugil_pkg::ST_OUT;
        end else begin
          state_d = ugil_pkg::ST_C3_EV;
        end
      end
      ugil_pkg::ST_C3_EV: begin
        if (code_q == w.third_byte) begin
          res_d = '{bytes_used: 2'd3, glyph_set: ugil_pkg::SET_THREE,
                    glyph_index: pos_q[12:0]};
          state_d = ugil_pkg::ST_OUT;
        end else begin
          pos_d = pos_q + 18'd1;
          j_d = j_q + 7'd1;
          state_d = ugil_pkg::ST_C3_RD;
        end
      end
      ugil_pkg::ST_OUT: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          pop = 1'b1;
          state_d = ugil_pkg::ST_IDLE;
        end
      end
      default: state_d = ugil_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ugil_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    j_q     <= j_d;
    mid_q   <= mid_d;
    pos_q   <= pos_d;
    inner_q <= inner_d;
    res_q   <= res_d;
    if (state_q == ugil_pkg::ST_OUT && (!ovalid_q || !out_stall_i)) begin
      oword_q <= res_q;
    end
  end

  a_pop_when_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i) else $error("pop without queued word");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o)) else $error("stalled result changed");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bytes_used == 2'd0 |-> out_data_o.glyph_index == 13'd0)
    else $error("miss with nonzero index");

endmodule

/* hw/rtl/utf8_glyph_index_lookup_top.sv */
// Flow: a lookup whose lead byte alone decides it goes from the idle state straight to
// the output state; a walk adds a read and an evaluate state for each table entry it reads.
// Load words are written in the idle state; words pass a two-entry queue first.
// Throughput: one word at a time in the back end; a full three-byte walk can read
// up to 16 leads, 256 second entries and 127 codes.
// Reset: asynchronous active low; clears control and both counters, not tables.
module utf8_glyph_index_lookup_top #(
  parameter int unsigned LEAD2_DEPTH   = ugil_pkg::LEAD2_DEPTH_DEF,
  parameter int unsigned LEAD3_DEPTH   = ugil_pkg::LEAD3_DEPTH_DEF,
  parameter int unsigned SECOND3_DEPTH = ugil_pkg::SECOND3_DEPTH_DEF,
  parameter int unsigned CODES2_DEPTH  = ugil_pkg::CODES2_DEPTH_DEF,
  parameter int unsigned CODES3_DEPTH  = ugil_pkg::CODES3_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ugil_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ugil_pkg::out_word_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [4:0]          cfg_data_i
);

  logic [4:0] leads2_q, leads3_q;
  logic q_valid, q_pop;
  ugil_pkg::cmd_t q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leads2_q <= '0;
      leads3_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == ugil_pkg::REG_LEADS2) begin
        leads2_q <= cfg_data_i;
      end else begin
        leads3_q <= cfg_data_i;
      end
    end
  end

  ugil_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_cmd_o   (q_cmd)
  );

  ugil_back #(
    .LEAD2_DEPTH(LEAD2_DEPTH), .LEAD3_DEPTH(LEAD3_DEPTH),
    .SECOND3_DEPTH(SECOND3_DEPTH), .CODES2_DEPTH(CODES2_DEPTH),
    .CODES3_DEPTH(CODES3_DEPTH)
  ) u_back (
    .clk_i, .rst_ni,
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_cmd_i    (q_cmd),
    .leads2_i   (leads2_q),
    .leads3_i   (leads3_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

/* bench/utf8_glyph_index_lookup_checker.sv */
module utf8_glyph_index_lookup_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ugil_pkg::in_word_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ugil_pkg::out_word_t out_data_i,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [4:0]          cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [4:0]  leads2_used;
  logic [4:0]  leads3_used;
  logic [14:0] lead2_mem [ugil_pkg::LEAD2_DEPTH_DEF];
  logic [14:0] lead3_mem [ugil_pkg::LEAD3_DEPTH_DEF];
  logic [14:0] second3_mem [ugil_pkg::SECOND3_DEPTH_DEF];
  logic [7:0]  codes2_mem [ugil_pkg::CODES2_DEPTH_DEF];
  logic [7:0]  codes3_mem [ugil_pkg::CODES3_DEPTH_DEF];
  ugil_pkg::out_word_t glyphs_due [$];

  initial fail_count_o = 0;
  assign pending_o = glyphs_due.size();

  function automatic int walk_two(logic [7:0] b0, logic [7:0] b1);
    int pos;
    pos = 0;
    for (int i = 0; i < leads2_used; i++) begin
      if (i >= ugil_pkg::LEAD2_DEPTH_DEF) return -1;
      if (lead2_mem[i][7:0] == b0) begin
        for (int j = 0; j < lead2_mem[i][14:8]; j++) begin
          if (pos >= ugil_pkg::CODES2_DEPTH_DEF) return -1;
          if (codes2_mem[pos] == b1) return pos;
          pos++;
        end
      end else begin
        pos += lead2_mem[i][14:8];
      end
    end
    return -1;
  endfunction

  function automatic int walk_three(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    int mid;
    int pos;
    mid = 0;
    pos = 0;
    for (int i = 0; i < leads3_used; i++) begin
      if (i >= ugil_pkg::LEAD3_DEPTH_DEF) return -1;
      for (int j = 0; j < lead3_mem[i][14:8]; j++) begin
        if (mid >= ugil_pkg::SECOND3_DEPTH_DEF) return -1;
        if (lead3_mem[i][7:0] == b0 && second3_mem[mid][7:0] == b1) begin
          for (int k = 0; k < second3_mem[mid][14:8]; k++) begin
            if (pos >= ugil_pkg::CODES3_DEPTH_DEF) return -1;
            if (codes3_mem[pos] == b2) return pos;
            pos++;
          end
          return -1;
        end
        pos += second3_mem[mid][14:8];
        mid++;
      end
    end
    return -1;
  endfunction

  function automatic ugil_pkg::out_word_t glyph_of(ugil_pkg::in_word_t w);
    ugil_pkg::out_word_t r;
    int pos;
    r = '0;
    if ((w.first_byte & ugil_pkg::MASK_B7) == 8'h00) begin
      r.bytes_used = 2'd1;
      r.glyph_set = ugil_pkg::SET_ONE;
      r.glyph_index = 13'(w.first_byte);
    end else if ((w.first_byte & ugil_pkg::MASK_2B) == ugil_pkg::LEAD_2B) begin
      pos = walk_two(w.first_byte, w.second_byte);
      if (pos >= 0) begin
        r.bytes_used = 2'd2;
        r.glyph_set = ugil_pkg::SET_TWO;
        r.glyph_index = 13'(pos);
      end
    end else if ((w.first_byte & ugil_pkg::MASK_3B) == ugil_pkg::LEAD_3B) begin
      pos = walk_three(w.first_byte, w.second_byte, w.third_byte);
      if (pos >= 0) begin
        r.bytes_used = 2'd3;
        r.glyph_set = ugil_pkg::SET_THREE;
        r.glyph_index = 13'(pos);
      end
    end
    return r;
  endfunction

  task automatic report(string what, int want, int got);
    $display("[%0t] mismatch in %s: expected %0d, got %0d", $time, what, want, got);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ugil_pkg::out_word_t want;
    if (!rst_ni) begin
      leads2_used <= '0;
      leads3_used <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == ugil_pkg::REG_LEADS2) leads2_used <= cfg_data_i;
        else leads3_used <= cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.func)
          ugil_pkg::FUNC_LOOKUP: glyphs_due.push_back(glyph_of(in_data_i));
          ugil_pkg::FUNC_LEAD2: if (in_data_i.entry_index < ugil_pkg::LEAD2_DEPTH_DEF)
            lead2_mem[in_data_i.entry_index] = {in_data_i.entry_count, in_data_i.entry_byte};
          ugil_pkg::FUNC_LEAD3: if (in_data_i.entry_index < ugil_pkg::LEAD3_DEPTH_DEF)
            lead3_mem[in_data_i.entry_index] = {in_data_i.entry_count, in_data_i.entry_byte};
          ugil_pkg::FUNC_SECOND3: if (in_data_i.entry_index < ugil_pkg::SECOND3_DEPTH_DEF)
            second3_mem[in_data_i.entry_index] =
              {in_data_i.entry_count, in_data_i.entry_byte};
          ugil_pkg::FUNC_CODES2: if (in_data_i.entry_index < ugil_pkg::CODES2_DEPTH_DEF)
            codes2_mem[in_data_i.entry_index] = in_data_i.entry_byte;
          ugil_pkg::FUNC_CODES3: if (in_data_i.entry_index < ugil_pkg::CODES3_DEPTH_DEF)
            codes3_mem[in_data_i.entry_index] = in_data_i.entry_byte;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (glyphs_due.size() == 0) begin
          report("unexpected result word", 0, 1);
        end else begin
          want = glyphs_due.pop_front();
          if (out_data_i.bytes_used !== want.bytes_used)
            report("bytes_used", want.bytes_used, out_data_i.bytes_used);
          if (out_data_i.glyph_set !== want.glyph_set)
            report("glyph_set", want.glyph_set, out_data_i.glyph_set);
          if (out_data_i.glyph_index !== want.glyph_index)
            report("glyph_index", want.glyph_index, out_data_i.glyph_index);
        end
      end
    end
  end

endmodule

/* bench/utf8_glyph_index_lookup_top_tb.sv */
module utf8_glyph_index_lookup_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 10000000;
  localparam int DRAIN_CYCLES = 300;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  ugil_pkg::in_word_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  ugil_pkg::out_word_t out_data;
  logic       cfg_we = 1'b0;
  logic       cfg_index = ugil_pkg::REG_LEADS2;
  logic [4:0] cfg_data = '0;
  int         fail_count;
  int         pending;
  int         sender_idle_pct = 0;
  int         rx_stall_pct = 0;
  int         cycles = 0;
  int         words_sent = 0;
  int         lookups_sent = 0;
  int         settings_used = 0;

  logic [7:0] lead2_b [16];
  logic [6:0] lead2_c [16];
  logic [7:0] lead3_b [16];
  logic [6:0] lead3_c [16];
  logic [7:0] sec3_b [256];
  logic [6:0] sec3_c [256];
  logic [7:0] codes2_b [1024];
  logic [7:0] codes3_b [8192];
  int         n_codes2 = 0;
  int         n_sec3 = 0;
  int         n_codes3 = 0;

  utf8_glyph_index_lookup_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  utf8_glyph_index_lookup_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("utf8_glyph_index_lookup_top regression: fail");
      $finish;
    end
  end

  task automatic send_word(ugil_pkg::in_word_t w);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (w.func == ugil_pkg::FUNC_LOOKUP) lookups_sent++;
  endtask

  task automatic load_entry(logic [2:0] fn, int idx, logic [7:0] b, logic [6:0] c);
    ugil_pkg::in_word_t w;
    w = ugil_pkg::in_word_t'({$urandom, $urandom});
    w.func = fn;
    w.entry_index = 13'(idx);
    w.entry_byte = b;
    w.entry_count = c;
    send_word(w);
  endtask

  task automatic lookup(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    ugil_pkg::in_word_t w;
    w = ugil_pkg::in_word_t'({$urandom, $urandom});
    w.func = ugil_pkg::FUNC_LOOKUP;
    w.first_byte = b0;
    w.second_byte = b1;
    w.third_byte = b2;
    send_word(w);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_leads(logic [4:0] two, logic [4:0] three);
    cfg_we <= 1'b1;
    cfg_index <= ugil_pkg::REG_LEADS2;
    cfg_data <= two;
    @(posedge clk);
    cfg_index <= ugil_pkg::REG_LEADS3;
    cfg_data <= three;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Every entry a walk can reach is loaded, so no lookup reads an unwritten entry.
  task automatic fill_tables(int c2max, int c3max, int csmax, bit wide_lead);
    int total;
    total = 0;
    for (int i = 0; i < 16; i++) begin
      lead2_b[i] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'hC0 + 8'($urandom_range(0, 3));
      lead2_c[i] = (wide_lead && i == 0) ? 7'd64 : 7'($urandom_range(0, c2max));
      load_entry(ugil_pkg::FUNC_LEAD2, i, lead2_b[i], lead2_c[i]);
      total += lead2_c[i];
    end
    n_codes2 = (total > 1024) ? 1024 : total;
    for (int p = 0; p < n_codes2; p++) begin
      codes2_b[p] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h80 + 8'($urandom_range(0, 5));
      load_entry(ugil_pkg::FUNC_CODES2, p, codes2_b[p], 7'($urandom));
    end
    total = 0;
    for (int i = 0; i < 16; i++) begin
      lead3_b[i] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'hE0 + 8'($urandom_range(0, 3));
      lead3_c[i] = 7'($urandom_range(0, c3max));
      load_entry(ugil_pkg::FUNC_LEAD3, i, lead3_b[i], lead3_c[i]);
      total += lead3_c[i];
    end
    n_sec3 = (total > 256) ? 256 : total;
    total = 0;
    for (int m = 0; m < n_sec3; m++) begin
      sec3_b[m] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h80 + 8'($urandom_range(0, 3));
      sec3_c[m] = 7'($urandom_range(0, csmax));
      load_entry(ugil_pkg::FUNC_SECOND3, m, sec3_b[m], sec3_c[m]);
      total += sec3_c[m];
    end
    n_codes3 = total;
    for (int p = 0; p < n_codes3; p++) begin
      codes3_b[p] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h80 + 8'($urandom_range(0, 5));
      load_entry(ugil_pkg::FUNC_CODES3, p, codes3_b[p], 7'($urandom));
    end
  endtask

  task automatic random_word();
    int pick;
    ugil_pkg::in_word_t w;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    pick = $urandom_range(0, 19);
    b1 = 8'($urandom);
    b2 = 8'($urandom);
    if (pick == 0) begin
      w = ugil_pkg::in_word_t'({$urandom, $urandom});
      w.func = 3'($urandom_range(6, 7));
      send_word(w);
    end else if (pick == 1) begin
      case ($urandom_range(0, 3))
        0: load_entry(ugil_pkg::FUNC_LEAD2, $urandom_range(16, 8191), 8'($urandom),
                      7'($urandom));
        1: load_entry(ugil_pkg::FUNC_LEAD3, $urandom_range(16, 8191), 8'($urandom),
                      7'($urandom));
        2: load_entry(ugil_pkg::FUNC_SECOND3, $urandom_range(256, 8191), 8'($urandom),
                      7'($urandom));
        default: load_entry(ugil_pkg::FUNC_CODES2, $urandom_range(1024, 8191), 8'($urandom),
                            7'($urandom));
      endcase
    end else if (pick < 5) begin
      b0 = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 127)) : 8'($urandom);
      lookup(b0, b1, b2);
    end else if (pick < 12) begin
      b0 = ($urandom_range(0, 4) == 0) ? 8'hC0 + 8'($urandom_range(0, 31))
                                       : lead2_b[$urandom_range(0, 15)];
      if (n_codes2 > 0 && $urandom_range(0, 4) != 0) b1 = codes2_b[$urandom_range(0, n_codes2 - 1)];
      lookup(b0, b1, b2);
    end else begin
      b0 = ($urandom_range(0, 4) == 0) ? 8'hE0 + 8'($urandom_range(0, 15))
                                       : lead3_b[$urandom_range(0, 15)];
      if (n_sec3 > 0 && $urandom_range(0, 4) != 0) b1 = sec3_b[$urandom_range(0, n_sec3 - 1)];
      if (n_codes3 > 0 && $urandom_range(0, 4) != 0) b2 = codes3_b[$urandom_range(0, n_codes3 - 1)];
      lookup(b0, b1, b2);
    end
  endtask

  initial begin
    logic [4:0] two_cfg [6];
    logic [4:0] three_cfg [6];
    two_cfg = '{5'd16, 5'd0, 5'd31, 5'd7, 5'd16, 5'd1};
    three_cfg = '{5'd16, 5'd16, 5'd17, 5'd0, 5'd31, 5'd9};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_leads(5'd0, 5'd0);
    lookup(8'h00, 8'h00, 8'h00);
    lookup(8'h7F, 8'hFF, 8'hFF);
    lookup(8'h80, 8'h80, 8'h80);
    lookup(8'hBF, 8'h00, 8'h00);
    lookup(8'hF0, 8'h90, 8'h80);
    lookup(8'hF8, 8'h80, 8'h80);
    lookup(8'hFF, 8'hFF, 8'hFF);
    lookup(8'hC2, 8'hA9, 8'h00);
    lookup(8'hE2, 8'h82, 8'hAC);
    load_entry(3'd6, 0, 8'hFF, 7'h7F);
    load_entry(3'd7, 8191, 8'hFF, 7'h7F);
    fill_tables(2, 2, 3, 1'b1);
    wait_idle();
    set_leads(5'd16, 5'd16);
    lookup(lead2_b[0], codes2_b[0], 8'h00);
    lookup(lead2_b[0], codes2_b[63], 8'h00);
    lookup(lead2_b[15], 8'h80, 8'h00);
    lookup(lead3_b[0], sec3_b[0], 8'h80);
    lookup(lead3_b[15], 8'h81, 8'h82);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      sender_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 71 : 0;
      rx_stall_pct = (ph < 2) ? 71 : (ph < 4) ? 10 : 0;
      if (ph == 1) fill_tables(3, 20, 1, 1'b0);
      else fill_tables(3, 3, 3, 1'b0);
      wait_idle();
      set_leads(two_cfg[ph], three_cfg[ph]);
      for (int n = 0; n < 180; n++) begin
        random_word();
        if (n == 90 && ph == 2) begin
          in_valid <= 1'b0;
          while (pending != 0) @(posedge clk);
        end
      end
      wait_idle();
    end

    $display("%0d words sent, %0d of them lookups, across %0d lead-count settings",
             words_sent, lookups_sent, settings_used);
    $display("stall mixes: sender-light/receiver-heavy, the reverse, and no stalls");
    if (fail_count == 0) begin
      $display("utf8_glyph_index_lookup_top regression: pass");
    end else begin
      $display("utf8_glyph_index_lookup_top regression: fail");
    end
    $finish;
  end

endmodule
